[rtl/core/value_list_filter_engine_core_macros.svh]
`ifndef VALUE_LIST_FILTER_ENGINE_CORE_MACROS_SVH
`define VALUE_LIST_FILTER_ENGINE_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define VLFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vlfe: assertion failed");

// next-cycle implication, held off during reset
`define VLFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vlfe: assertion failed");

`endif

[rtl/core/vlfe_pkg.sv]
`timescale 1ns / 1ps

package vlfe_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;
    localparam logic [1:0] CMD_FILT = 2'd3;

    localparam logic [1:0] MODE_LT = 2'd0;
    localparam logic [1:0] MODE_EQ = 2'd1;
    localparam logic [1:0] MODE_GT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] operand;
        logic [1:0]         compare_mode;
    } t_in;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic [4:0]         removed_count;
    } t_out;

    typedef logic [3:0] t_upc;

    localparam t_upc UPC_IDLE      = 4'd0;
    localparam t_upc UPC_PUSH      = 4'd1;
    localparam t_upc UPC_POP       = 4'd2;
    localparam t_upc UPC_POP_OUT   = 4'd3;
    localparam t_upc UPC_FIND_INIT = 4'd4;
    localparam t_upc UPC_FIND_LOOP = 4'd5;
    localparam t_upc UPC_FIND_OUT  = 4'd6;
    localparam t_upc UPC_FILT_INIT = 4'd7;
    localparam t_upc UPC_FILT_LOOP = 4'd8;
    localparam t_upc UPC_FILT_OUT  = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH,
        OP_POP,
        OP_POP_OUT,
        OP_SCAN_INIT,
        OP_FIND,
        OP_FILT,
        OP_FILT_OUT
    } t_op;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_GOTO,
        JC_DISPATCH,
        JC_LOOP
    } t_jc;

    typedef struct packed {
        logic busy;
        logic emit;
        t_op  op;
        t_jc  jc;
        t_upc target;
    } t_ctrl;

    typedef struct packed {
        logic more;
    } t_flags;

    function automatic t_ctrl uc_word(input logic busy, input logic emit, input t_op op,
                                      input t_jc jc, input t_upc target);
        t_ctrl w;
        w.busy   = busy;
        w.emit   = emit;
        w.op     = op;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // microprogram
    function automatic t_ctrl uc_rom(input t_upc upc);
        t_ctrl w;
        w = uc_word(1'b0, 1'b0, OP_LOAD, JC_DISPATCH, UPC_IDLE);
        unique case (upc)
            UPC_IDLE:      w = uc_word(1'b0, 1'b0, OP_LOAD,      JC_DISPATCH, UPC_IDLE);
            UPC_PUSH:      w = uc_word(1'b1, 1'b1, OP_PUSH,      JC_GOTO,     UPC_IDLE);
            UPC_POP:       w = uc_word(1'b1, 1'b0, OP_POP,       JC_NEXT,     UPC_IDLE);
            UPC_POP_OUT:   w = uc_word(1'b1, 1'b1, OP_POP_OUT,   JC_GOTO,     UPC_IDLE);
            UPC_FIND_INIT: w = uc_word(1'b1, 1'b0, OP_SCAN_INIT, JC_NEXT,     UPC_IDLE);
            UPC_FIND_LOOP: w = uc_word(1'b1, 1'b0, OP_FIND,      JC_LOOP,     UPC_IDLE);
            UPC_FIND_OUT:  w = uc_word(1'b1, 1'b1, OP_NONE,      JC_GOTO,     UPC_IDLE);
            UPC_FILT_INIT: w = uc_word(1'b1, 1'b0, OP_SCAN_INIT, JC_NEXT,     UPC_IDLE);
            UPC_FILT_LOOP: w = uc_word(1'b1, 1'b0, OP_FILT,      JC_LOOP,     UPC_IDLE);
            UPC_FILT_OUT:  w = uc_word(1'b1, 1'b1, OP_FILT_OUT,  JC_GOTO,     UPC_IDLE);
            default:       w = uc_word(1'b1, 1'b0, OP_NONE,      JC_GOTO,     UPC_IDLE);
        endcase
        return w;
    endfunction

endpackage

[rtl/core/vlfe_ram.sv]
`timescale 1ns / 1ps

module vlfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/vlfe_seq.sv]
`timescale 1ns / 1ps

module vlfe_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_cmd,
    input  vlfe_pkg::t_flags  i_flags,
    output vlfe_pkg::t_ctrl   o_ctrl
);

    vlfe_pkg::t_upc  r_upc;
    vlfe_pkg::t_upc  n_upc;
    vlfe_pkg::t_ctrl w_ctrl;

    assign w_ctrl = vlfe_pkg::uc_rom(r_upc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        n_upc = r_upc;
        unique case (w_ctrl.jc)
            vlfe_pkg::JC_NEXT: n_upc = r_upc + vlfe_pkg::t_upc'(1);
            vlfe_pkg::JC_GOTO: n_upc = w_ctrl.target;
            vlfe_pkg::JC_LOOP: n_upc = i_flags.more ? r_upc : r_upc + vlfe_pkg::t_upc'(1);
            vlfe_pkg::JC_DISPATCH: begin
                if (i_start) begin
                    unique case (i_cmd)
                        vlfe_pkg::CMD_PUSH: n_upc = vlfe_pkg::UPC_PUSH;
                        vlfe_pkg::CMD_POP:  n_upc = vlfe_pkg::UPC_POP;
                        vlfe_pkg::CMD_FIND: n_upc = vlfe_pkg::UPC_FIND_INIT;
                        default:            n_upc = vlfe_pkg::UPC_FILT_INIT;
                    endcase
                end
            end
            default: n_upc = vlfe_pkg::UPC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= vlfe_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[rtl/core/vlfe_dp.sv]
`timescale 1ns / 1ps

module vlfe_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vlfe_pkg::t_in     i_item,
    input  vlfe_pkg::t_ctrl   i_ctrl,
    output vlfe_pkg::t_flags  o_flags,
    output logic              o_result_valid,
    output vlfe_pkg::t_out    o_result
);

    logic [vlfe_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [vlfe_pkg::CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [vlfe_pkg::CNT_W-1:0] r_wr_idx, n_wr_idx;
    logic [vlfe_pkg::CNT_W-1:0] r_removed, n_removed;
    logic [vlfe_pkg::CNT_W-1:0] w_cnt_dec;
    logic                       r_pend, n_pend;
    logic                       r_found, n_found;
    logic [1:0]                 r_status, n_status;
    logic signed [31:0]         r_key, n_key;
    logic [1:0]                 r_mode, n_mode;
    logic signed [31:0]         r_popped, n_popped;
    logic                       r_res_valid;
    vlfe_pkg::t_out             r_res, n_res;
    logic                       w_more;
    logic                       w_match;

    logic                        ram_we;
    logic [vlfe_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                 ram_wdata;
    logic [vlfe_pkg::ADDR_W-1:0] ram_raddr;
    logic [31:0]                 ram_rdata;

    vlfe_ram #(
        .WIDTH (32),
        .DEPTH (vlfe_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_more    = r_rd_idx < r_cnt;
    assign w_cnt_dec = r_cnt - vlfe_pkg::CNT_W'(1);
    assign o_flags.more = w_more;

    always_comb begin
        w_match = 1'b0;
        case (r_mode)
            vlfe_pkg::MODE_LT: w_match = $signed(ram_rdata) < r_key;
            vlfe_pkg::MODE_EQ: w_match = $signed(ram_rdata) == r_key;
            vlfe_pkg::MODE_GT: w_match = $signed(ram_rdata) > r_key;
            default:           w_match = 1'b0;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_removed = r_removed;
        n_pend    = r_pend;
        n_found   = r_found;
        n_status  = r_status;
        n_key     = r_key;
        n_mode    = r_mode;
        n_popped  = r_popped;
        ram_we    = 1'b0;
        ram_waddr = r_wr_idx[vlfe_pkg::ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_rd_idx[vlfe_pkg::ADDR_W-1:0];

        unique case (i_ctrl.op)
            vlfe_pkg::OP_LOAD: begin
                if (i_start) begin
                    n_key     = i_item.operand;
                    n_mode    = i_item.compare_mode;
                    n_found   = 1'b0;
                    n_status  = vlfe_pkg::ST_OK;
                    n_removed = '0;
                    n_popped  = '0;
                end
            end
            vlfe_pkg::OP_PUSH: begin
                if (r_cnt >= vlfe_pkg::CNT_W'(vlfe_pkg::DEPTH)) begin
                    n_status = vlfe_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[vlfe_pkg::ADDR_W-1:0];
                    ram_wdata = r_key;
                    n_cnt     = r_cnt + vlfe_pkg::CNT_W'(1);
                end
            end
            vlfe_pkg::OP_POP: begin
                ram_raddr = w_cnt_dec[vlfe_pkg::ADDR_W-1:0];
                if (r_cnt == '0) begin
                    n_status = vlfe_pkg::ST_EMPTY;
                end else begin
                    n_cnt = w_cnt_dec;
                end
            end
            vlfe_pkg::OP_POP_OUT: begin
                if (r_status == vlfe_pkg::ST_OK) begin
                    n_popped = ram_rdata;
                end
            end
            vlfe_pkg::OP_SCAN_INIT: begin
                n_rd_idx = '0;
                n_wr_idx = '0;
                n_pend   = 1'b0;
            end
            vlfe_pkg::OP_FIND: begin
                if (r_pend && ($signed(ram_rdata) == r_key)) begin
                    n_found = 1'b1;
                end
                n_pend = w_more;
                if (w_more) begin
                    n_rd_idx = r_rd_idx + vlfe_pkg::CNT_W'(1);
                end
            end
            vlfe_pkg::OP_FILT: begin
                // compaction writes trail the reads, so no slot is overwritten unread
                if (r_pend) begin
                    if (w_match) begin
                        n_removed = r_removed + vlfe_pkg::CNT_W'(1);
                    end else begin
                        ram_we   = 1'b1;
                        n_wr_idx = r_wr_idx + vlfe_pkg::CNT_W'(1);
                    end
                end
                n_pend = w_more;
                if (w_more) begin
                    n_rd_idx = r_rd_idx + vlfe_pkg::CNT_W'(1);
                end
            end
            vlfe_pkg::OP_FILT_OUT: begin
                n_cnt = r_wr_idx;
            end
            default: begin
            end
        endcase

        n_res.popped_value  = n_popped;
        n_res.found         = n_found;
        n_res.status        = n_status;
        n_res.entry_count   = 5'(n_cnt);
        n_res.removed_count = 5'(n_removed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_res_valid <= i_ctrl.emit;
        end
        r_rd_idx  <= n_rd_idx;
        r_wr_idx  <= n_wr_idx;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_status  <= n_status;
        r_key     <= n_key;
        r_mode    <= n_mode;
        r_popped  <= n_popped;
        if (i_ctrl.emit) begin
            r_res <= n_res;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

[rtl/core/value_list_filter_engine_core.sv]
`timescale 1ns / 1ps
// Channel   Handshake                      Payload
// command   start, accepted when !busy     i_item   (vlfe_pkg::t_in)
// result    o_result_valid, one cycle      o_result (vlfe_pkg::t_out)
//
// Push runs the PUSH microcode step; pop runs POP, then POP_OUT, which takes the read data.
// Membership test and filtered removal run an init step, then the microcode scan loop
// reading one store entry per cycle through the RAM read port, then an output step.
// busy drops in the strobe cycle, so the next command can be taken there.
// Reset (synchronous) empties the list and returns the sequencer to idle; the store
// itself is not cleared. The receiver cannot stall the result.

`include "value_list_filter_engine_core_macros.svh"

module value_list_filter_engine_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  vlfe_pkg::t_in  i_item,
    output logic           o_result_valid,
    output vlfe_pkg::t_out o_result
);

    vlfe_pkg::t_ctrl  w_ctrl;
    vlfe_pkg::t_flags w_flags;

    vlfe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.command),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    vlfe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_item         (i_item),
        .i_ctrl         (w_ctrl),
        .o_flags        (w_flags),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    assign busy = w_ctrl.busy;

    `VLFE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `VLFE_ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `VLFE_ASSERT_NEXT(a_result_once, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `VLFE_ASSERT_IMPL(a_full_count, i_clk, i_rst_n,
        o_result_valid && (o_result.status == vlfe_pkg::ST_FULL),
        o_result.entry_count == 5'(vlfe_pkg::DEPTH))

endmodule
